// ===== hw/rtl/stereo_frame_ring_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO assertion macros
// Shared concurrent assertion forms used by the FIFO modules.
// ----------------------------------------------------------------------------
`ifndef STEREO_FRAME_RING_FIFO_ASSERT_SVH
`define STEREO_FRAME_RING_FIFO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("FIFO assertion failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define SFRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("FIFO assertion failed: next-cycle rule");

`endif

// ===== hw/rtl/sfrf_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO package
// Shared constants, codes and control/status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfrf_pkg;

	localparam int DEPTH_DEF    = 4096;
	localparam int MAX_PULL_DEF = 64;

	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 13;
	localparam int PULL_W   = 7;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_PULL  = 1'b1;

	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_PULL
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              wr_frame;
		logic              pull_start;
		logic [PULL_W-1:0] pull_take;
		logic              rd_issue;
		logic              rd_pad;
		logic              rd_end;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              s1_busy;
		logic              s1_free;
		logic              out_blocked;
		logic [PULL_W-1:0] level_clip;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfrf_datapath.sv =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO datapath
// Frame store, ring addresses, queue level, read stage and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_frame_ring_fifo_assert.svh"

module sfrf_datapath #(
	parameter int DEPTH    = sfrf_pkg::DEPTH_DEF,
	parameter int MAX_PULL = sfrf_pkg::MAX_PULL_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire sfrf_pkg::ctl_cmd_t            cmd,
	output sfrf_pkg::dp_status_t               status,
	input  wire                                burst_first,
	input  wire                                burst_last,
	input  wire [sfrf_pkg::COUNT_W-1:0]        burst_frames,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]       left_in,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]       right_in,
	input  wire                                out_stall,
	output logic                               out_valid,
	output logic                               kind,
	output logic [sfrf_pkg::SAMPLE_W-1:0]      left_out,
	output logic [sfrf_pkg::SAMPLE_W-1:0]      right_out,
	output logic                               padded,
	output logic                               accepted,
	output logic [sfrf_pkg::COUNT_W-1:0]       queued,
	output logic                               run_end
);

	localparam int SW = sfrf_pkg::SAMPLE_W;
	localparam int PW = sfrf_pkg::PULL_W;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = ((LW > sfrf_pkg::COUNT_W) ? LW : sfrf_pkg::COUNT_W) + 1;

	logic [2*SW-1:0] mem [DEPTH];

	logic [AW-1:0]   wr_addr_q;
	logic [AW-1:0]   rd_addr_q;
	logic [LW-1:0]   level_q;
	logic            taking_q;

	logic            s1_valid_s1;
	logic            pad_s1;
	logic            end_s1;
	logic [2*SW-1:0] rd_data_s1;

	logic            out_valid_q;

	logic [CW-1:0]   fit_sum;
	logic            taking_c;
	logic            store_c;
	logic [LW-1:0]   level_after;
	logic            report_c;
	logic            out_blocked;
	logic            s1_move;
	logic            rd_mem_en;

	always_comb begin
		fit_sum     = CW'(level_q) + CW'(burst_frames);
		taking_c    = burst_first ? (fit_sum <= CW'(DEPTH)) : taking_q;
		store_c     = cmd.wr_frame && taking_c && (level_q != LW'(DEPTH));
		level_after = store_c ? LW'(level_q + LW'(1)) : level_q;
		report_c    = cmd.wr_frame && burst_last;
		out_blocked = out_valid_q && out_stall;
		s1_move     = s1_valid_s1 && !out_blocked;
		rd_mem_en   = cmd.rd_issue && !cmd.rd_pad;
	end

	always_comb begin
		status.s1_busy     = s1_valid_s1;
		status.s1_free     = !s1_valid_s1 || !out_blocked;
		status.out_blocked = out_blocked;
		if (32'(level_q) > 32'(MAX_PULL)) begin
			status.level_clip = PW'(MAX_PULL);
		end else begin
			status.level_clip = PW'(level_q);
		end
	end

	// Frame store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (store_c) begin
			mem[wr_addr_q] <= {right_in, left_in};
		end
		if (rd_mem_en) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q <= '0;
			rd_addr_q <= '0;
			level_q   <= '0;
			taking_q  <= 1'b0;
		end else begin
			if (cmd.wr_frame) begin
				taking_q <= burst_last ? 1'b0 : taking_c;
				level_q  <= level_after;
			end else if (cmd.pull_start) begin
				// The level drops by the whole take at once; the input side
				// stays stalled until the pull has drained.
				level_q <= LW'(level_q - LW'(cmd.pull_take));
			end
			if (store_c) begin
				wr_addr_q <= (wr_addr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_addr_q + AW'(1));
			end
			if (rd_mem_en) begin
				rd_addr_q <= (rd_addr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_addr_q + AW'(1));
			end
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (cmd.rd_issue) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			pad_s1 <= cmd.rd_pad;
			end_s1 <= cmd.rd_end;
		end
	end

	// Output register: a pulled frame from the read stage or a burst report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move || report_c) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_c) begin
			kind      <= sfrf_pkg::KIND_REPORT;
			left_out  <= '0;
			right_out <= '0;
			padded    <= 1'b0;
			accepted  <= taking_c;
			queued    <= sfrf_pkg::COUNT_W'(level_after);
			run_end   <= 1'b1;
		end else if (s1_move) begin
			kind      <= sfrf_pkg::KIND_FRAME;
			left_out  <= pad_s1 ? '0 : rd_data_s1[SW-1:0];
			right_out <= pad_s1 ? '0 : rd_data_s1[2*SW-1:SW];
			padded    <= pad_s1;
			accepted  <= 1'b0;
			queued    <= sfrf_pkg::COUNT_W'(level_q);
			run_end   <= end_s1;
		end
	end

	assign out_valid = out_valid_q;

	`SFRF_ASSERT_NOW(a_level_bound, clk, arst_n, 1'b1, level_q <= LW'(DEPTH))
	`SFRF_ASSERT_NOW(a_report_no_clash, clk, arst_n, report_c, !s1_valid_s1)
	`SFRF_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_s1 && out_blocked,
		s1_valid_s1 && $stable(pad_s1) && $stable(end_s1))

endmodule

`default_nettype wire

// ===== hw/rtl/sfrf_controller.sv =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO controller
// Input handshake, pull sequencing and read commands for the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_frame_ring_fifo_assert.svh"

module sfrf_controller #(
	parameter int MAX_PULL = sfrf_pkg::MAX_PULL_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               func,
	input  wire [sfrf_pkg::PULL_W-1:0]        pull_frames,
	input  wire sfrf_pkg::dp_status_t         status,
	output sfrf_pkg::ctl_cmd_t                cmd
);

	localparam int PW = sfrf_pkg::PULL_W;

	sfrf_pkg::ctl_state_t state_q;
	sfrf_pkg::ctl_state_t state_d;

	logic [PW-1:0] want_q;
	logic [PW-1:0] take_q;
	logic [PW-1:0] idx_q;

	logic [PW-1:0] want_c;
	logic [PW-1:0] take_c;
	logic          accept;
	logic          pulling;
	logic          last_issue;

	always_comb begin
		want_c = (pull_frames > PW'(MAX_PULL)) ? PW'(MAX_PULL) : pull_frames;
		take_c = (status.level_clip < want_c) ? status.level_clip : want_c;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfrf_pkg::ST_IDLE: begin
				if (cmd.pull_start) begin
					state_d = sfrf_pkg::ST_PULL;
				end
			end
			sfrf_pkg::ST_PULL: begin
				if (cmd.rd_issue && last_issue) begin
					state_d = sfrf_pkg::ST_IDLE;
				end
			end
			default: state_d = sfrf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pulling        = 1'b0;
		unique case (state_q)
			sfrf_pkg::ST_IDLE: pulling = 1'b0;
			sfrf_pkg::ST_PULL: pulling = 1'b1;
			default:           pulling = 1'b0;
		endcase
		// A new item waits until the read stage has emptied so that results
		// leave in order.
		in_stall       = pulling || status.s1_busy || status.out_blocked;
		accept         = in_valid && !in_stall;
		last_issue     = (PW'(idx_q + PW'(1)) == want_q);
		cmd.wr_frame   = accept && (func == sfrf_pkg::FUNC_WRITE);
		cmd.pull_start = accept && (func == sfrf_pkg::FUNC_PULL) && (want_c != '0);
		cmd.pull_take  = take_c;
		cmd.rd_issue   = pulling && status.s1_free;
		cmd.rd_pad     = (idx_q >= take_q);
		cmd.rd_end     = last_issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfrf_pkg::ST_IDLE;
			want_q  <= '0;
			take_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.pull_start) begin
				want_q <= want_c;
				take_q <= take_c;
				idx_q  <= '0;
			end else if (cmd.rd_issue) begin
				idx_q <= PW'(idx_q + PW'(1));
			end
		end
	end

	`SFRF_ASSERT_NOW(a_idx_in_run, clk, arst_n, state_q == sfrf_pkg::ST_PULL, idx_q < want_q)
	`SFRF_ASSERT_NOW(a_take_le_want, clk, arst_n, state_q == sfrf_pkg::ST_PULL, take_q <= want_q)
	`SFRF_ASSERT_NEXT(a_pull_enters, clk, arst_n, cmd.pull_start,
		state_q == sfrf_pkg::ST_PULL && idx_q == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/stereo_frame_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO
// Stereo frame queue with all-or-nothing burst admission and zero padding.
// ----------------------------------------------------------------------------
// A write frame does not hold the input off; the last frame of a burst puts
// its report in the output register. A pull of N frames (N clipped to
// MAX_PULL) holds the input off while the controller issues one read or pad
// frame per cycle, as long as an output stall does not hold the full read
// stage; the frame store has one read port, and the next item is taken once
// the read stage behind that port has emptied. The store needs no clearing
// after reset, since only frames that were written are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_frame_ring_fifo #(
	parameter int DEPTH    = sfrf_pkg::DEPTH_DEF,
	parameter int MAX_PULL = sfrf_pkg::MAX_PULL_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               func,
	input  wire                               burst_first,
	input  wire                               burst_last,
	input  wire [sfrf_pkg::COUNT_W-1:0]       burst_frames,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]      left_in,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]      right_in,
	input  wire [sfrf_pkg::PULL_W-1:0]        pull_frames,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              kind,
	output logic [sfrf_pkg::SAMPLE_W-1:0]     left_out,
	output logic [sfrf_pkg::SAMPLE_W-1:0]     right_out,
	output logic                              padded,
	output logic                              accepted,
	output logic [sfrf_pkg::COUNT_W-1:0]      queued,
	output logic                              run_end
);

	sfrf_pkg::ctl_cmd_t   cmd;
	sfrf_pkg::dp_status_t status;

	sfrf_controller #(
		.MAX_PULL(MAX_PULL)
	) u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.pull_frames(pull_frames),
		.status     (status),
		.cmd        (cmd)
	);

	sfrf_datapath #(
		.DEPTH   (DEPTH),
		.MAX_PULL(MAX_PULL)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.burst_first (burst_first),
		.burst_last  (burst_last),
		.burst_frames(burst_frames),
		.left_in     (left_in),
		.right_in    (right_in),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.left_out    (left_out),
		.right_out   (right_out),
		.padded      (padded),
		.accepted    (accepted),
		.queued      (queued),
		.run_end     (run_end)
	);

endmodule

`default_nettype wire

// ===== bench/stereo_frame_ring_fifo_check.sv =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO checker
// Watches both channels of the FIFO and keeps its own copy of the queue.
// Every input transfer is turned into the results it must cause. Each output
// transfer is compared field by field against the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_frame_ring_fifo_check #(
	parameter int DEPTH    = sfrf_pkg::DEPTH_DEF,
	parameter int MAX_PULL = sfrf_pkg::MAX_PULL_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_stall,
	input  wire                               func,
	input  wire                               burst_first,
	input  wire                               burst_last,
	input  wire [sfrf_pkg::COUNT_W-1:0]       burst_frames,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]      left_in,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]      right_in,
	input  wire [sfrf_pkg::PULL_W-1:0]        pull_frames,
	input  wire                               out_valid,
	input  wire                               out_stall,
	input  wire                               kind,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]      left_out,
	input  wire [sfrf_pkg::SAMPLE_W-1:0]      right_out,
	input  wire                               padded,
	input  wire                               accepted,
	input  wire [sfrf_pkg::COUNT_W-1:0]       queued,
	input  wire                               run_end,
	output int                                failures,
	output int                                outstanding
);

	typedef struct packed {
		logic                          kind;
		logic [sfrf_pkg::SAMPLE_W-1:0] left;
		logic [sfrf_pkg::SAMPLE_W-1:0] right;
		logic                          padded;
		logic                          accepted;
		logic [sfrf_pkg::COUNT_W-1:0]  queued;
		logic                          run_end;
	} fifo_result_t;

	// Right sample in the upper half, left sample in the lower half.
	logic [2*sfrf_pkg::SAMPLE_W-1:0] frame_mem [DEPTH];
	int                              wr_pos;
	int                              rd_pos;
	bit                              burst_open;
	fifo_result_t                    results_due [$];
	int                              mismatch_total;

	// Positions run modulo twice the depth so that full and empty differ.
	function automatic int fifo_level();
		return (wr_pos + 2 * DEPTH - rd_pos) % (2 * DEPTH);
	endfunction

	task automatic predict_fifo_results(
		input logic                          f,
		input logic                          fst,
		input logic                          lst,
		input logic [sfrf_pkg::COUNT_W-1:0]  declared,
		input logic [sfrf_pkg::SAMPLE_W-1:0] l,
		input logic [sfrf_pkg::SAMPLE_W-1:0] r,
		input logic [sfrf_pkg::PULL_W-1:0]   req
	);
		int           level;
		int           want;
		int           take;
		fifo_result_t res;
		level = fifo_level();
		if (f == sfrf_pkg::FUNC_WRITE) begin
			if (fst)
				burst_open = (level + int'(declared) <= DEPTH);
			if (burst_open && level < DEPTH) begin
				frame_mem[wr_pos % DEPTH] = {r, l};
				wr_pos = (wr_pos + 1) % (2 * DEPTH);
			end
			if (lst) begin
				res = '0;
				res.kind = sfrf_pkg::KIND_REPORT;
				res.accepted = burst_open;
				res.queued = sfrf_pkg::COUNT_W'(fifo_level());
				res.run_end = 1'b1;
				results_due.push_back(res);
				burst_open = 1'b0;
			end
		end else begin
			want = (int'(req) > MAX_PULL) ? MAX_PULL : int'(req);
			take = (level < want) ? level : want;
			for (int i = 0; i < want; i++) begin
				res = '0;
				res.kind = sfrf_pkg::KIND_FRAME;
				res.queued = sfrf_pkg::COUNT_W'(level - take);
				res.run_end = (i == want - 1);
				if (i < take) begin
					res.left = frame_mem[rd_pos % DEPTH][sfrf_pkg::SAMPLE_W-1:0];
					res.right =
						frame_mem[rd_pos % DEPTH][2*sfrf_pkg::SAMPLE_W-1:sfrf_pkg::SAMPLE_W];
					rd_pos = (rd_pos + 1) % (2 * DEPTH);
				end else begin
					res.padded = 1'b1;
				end
				results_due.push_back(res);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] expd, input logic [31:0] got);
		if (got !== expd) begin
			$error("%s: expected %0h, got %0h", name, expd, got);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fifo_result_t due;
		if (!arst_n) begin
			wr_pos = 0;
			rd_pos = 0;
			burst_open = 1'b0;
			mismatch_total = 0;
			results_due.delete();
			failures <= 0;
			outstanding <= 0;
		end else begin
			// Inputs first: a result can never leave in the cycle its input arrives.
			if (in_valid && !in_stall)
				predict_fifo_results(func, burst_first, burst_last, burst_frames,
					left_in, right_in, pull_frames);
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("output transfer with no result expected");
					mismatch_total++;
				end else begin
					due = results_due.pop_front();
					check_field("kind", 32'(due.kind), 32'(kind));
					check_field("left_out", due.left, left_out);
					check_field("right_out", due.right, right_out);
					check_field("padded", 32'(due.padded), 32'(padded));
					check_field("accepted", 32'(due.accepted), 32'(accepted));
					check_field("queued", 32'(due.queued), 32'(queued));
					check_field("run_end", 32'(due.run_end), 32'(run_end));
				end
			end
			failures <= mismatch_total;
			outstanding <= results_due.size();
		end
	end

endmodule

// ===== bench/stereo_frame_ring_fifo_tb.sv =====
// ----------------------------------------------------------------------------
// Stereo frame ring FIFO testbench
// Drives write bursts and pull requests into the FIFO with random gaps and
// output stalls. A directed part covers the edge cases; a random part
// follows, whose first stretch runs with no gaps and no stalls. The checker
// beside the FIFO does all result checking; this module only gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_frame_ring_fifo_tb;

	localparam int DEPTH        = sfrf_pkg::DEPTH_DEF;
	localparam int MAX_PULL     = sfrf_pkg::MAX_PULL_DEF;
	localparam int RANDOM_ITEMS = 215;
	localparam int STEADY_ITEMS = 60;
	localparam int LIMIT_CYCLES = 400000;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          func = sfrf_pkg::FUNC_WRITE;
	logic                          burst_first = 1'b0;
	logic                          burst_last = 1'b0;
	logic [sfrf_pkg::COUNT_W-1:0]  burst_frames = '0;
	logic [sfrf_pkg::SAMPLE_W-1:0] left_in = '0;
	logic [sfrf_pkg::SAMPLE_W-1:0] right_in = '0;
	logic [sfrf_pkg::PULL_W-1:0]   pull_frames = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          kind;
	logic [sfrf_pkg::SAMPLE_W-1:0] left_out;
	logic [sfrf_pkg::SAMPLE_W-1:0] right_out;
	logic                          padded;
	logic                          accepted;
	logic [sfrf_pkg::COUNT_W-1:0]  queued;
	logic                          run_end;

	int failures;
	int outstanding;
	int cycle_count = 0;
	int items_sent = 0;
	bit steady = 1'b0;

	stereo_frame_ring_fifo #(
		.DEPTH(DEPTH),
		.MAX_PULL(MAX_PULL)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.burst_first(burst_first),
		.burst_last(burst_last),
		.burst_frames(burst_frames),
		.left_in(left_in),
		.right_in(right_in),
		.pull_frames(pull_frames),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.left_out(left_out),
		.right_out(right_out),
		.padded(padded),
		.accepted(accepted),
		.queued(queued),
		.run_end(run_end)
	);

	stereo_frame_ring_fifo_check #(
		.DEPTH(DEPTH),
		.MAX_PULL(MAX_PULL)
	) i_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.burst_first(burst_first),
		.burst_last(burst_last),
		.burst_frames(burst_frames),
		.left_in(left_in),
		.right_in(right_in),
		.pull_frames(pull_frames),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.left_out(left_out),
		.right_out(right_out),
		.padded(padded),
		.accepted(accepted),
		.queued(queued),
		.run_end(run_end),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("stereo_frame_ring_fifo verification failed");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(0, 99) < 33);

	// The payload is set together with valid and held until the transfer.
	task automatic send_item(
		input logic                          f,
		input logic                          fst,
		input logic                          lst,
		input logic [sfrf_pkg::COUNT_W-1:0]  declared,
		input logic [sfrf_pkg::SAMPLE_W-1:0] l,
		input logic [sfrf_pkg::SAMPLE_W-1:0] r,
		input logic [sfrf_pkg::PULL_W-1:0]   req
	);
		while (!steady && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		burst_first <= fst;
		burst_last <= lst;
		burst_frames <= declared;
		left_in <= l;
		right_in <= r;
		pull_frames <= req;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Without an opening frame the frames continue whatever burst is current.
	task automatic write_burst(input int frames, input logic [sfrf_pkg::COUNT_W-1:0] declared,
		input bit opened);
		for (int i = 0; i < frames; i++)
			send_item(sfrf_pkg::FUNC_WRITE, opened && i == 0, i == frames - 1,
				(i == 0) ? declared : sfrf_pkg::COUNT_W'($urandom), $urandom, $urandom,
				sfrf_pkg::PULL_W'($urandom));
	endtask

	task automatic pull_request(input logic [sfrf_pkg::PULL_W-1:0] req);
		send_item(sfrf_pkg::FUNC_PULL, 1'($urandom), 1'($urandom),
			sfrf_pkg::COUNT_W'($urandom), $urandom, $urandom, req);
	endtask

	initial begin
		int                           random_start;
		int                           choice;
		int                           frames;
		logic [sfrf_pkg::COUNT_W-1:0] declared;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pulls on an empty queue: nothing, one pad frame, a saturated run of pads.
		pull_request('0);
		pull_request(sfrf_pkg::PULL_W'(1));
		pull_request('1);
		// One-frame burst with all-ones samples, then a zero-count burst.
		send_item(sfrf_pkg::FUNC_WRITE, 1'b1, 1'b1, 13'd1, '1, '1,
			sfrf_pkg::PULL_W'($urandom));
		send_item(sfrf_pkg::FUNC_WRITE, 1'b1, 1'b0, '0, '0, '0,
			sfrf_pkg::PULL_W'($urandom));
		write_burst(2, sfrf_pkg::COUNT_W'($urandom), 1'b0);
		// Counts above the depth are always dropped.
		write_burst(2, '1, 1'b1);
		write_burst(1, sfrf_pkg::COUNT_W'(DEPTH + 1), 1'b1);
		// Frames with no open burst are dropped and reported as such.
		write_burst(2, sfrf_pkg::COUNT_W'($urandom), 1'b0);
		pull_request(sfrf_pkg::PULL_W'(MAX_PULL));
		pull_request(sfrf_pkg::PULL_W'(100));
		// Admission at exactly the depth, and one frame past it.
		write_burst(2, sfrf_pkg::COUNT_W'(DEPTH), 1'b1);
		write_burst(1, sfrf_pkg::COUNT_W'(DEPTH - 1), 1'b1);

		random_start = items_sent;
		steady <= 1'b1;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			if (items_sent >= random_start + STEADY_ITEMS)
				steady <= 1'b0;
			choice = $urandom_range(0, 99);
			if (choice < 50) begin
				frames = int'($urandom_range(1, 8));
				case ($urandom_range(0, 9))
					0: declared = '0;
					1: declared = sfrf_pkg::COUNT_W'($urandom);
					2: declared = sfrf_pkg::COUNT_W'(frames + int'($urandom_range(1, 4)));
					3: declared = sfrf_pkg::COUNT_W'(frames - 1);
					default: declared = sfrf_pkg::COUNT_W'(frames);
				endcase
				write_burst(frames, declared, 1'b1);
			end else if (choice < 68) begin
				pull_request(sfrf_pkg::PULL_W'($urandom_range(0, 10)));
			end else if (choice < 78) begin
				pull_request(sfrf_pkg::PULL_W'($urandom));
			end else if (choice < 90) begin
				write_burst(int'($urandom_range(1, 3)), sfrf_pkg::COUNT_W'($urandom), 1'b0);
			end else begin
				send_item(sfrf_pkg::FUNC_WRITE, 1'($urandom), 1'($urandom),
					sfrf_pkg::COUNT_W'($urandom), $urandom, $urandom,
					sfrf_pkg::PULL_W'($urandom));
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (MAX_PULL + 8) @(posedge clk);
		if (failures == 0)
			$display("stereo_frame_ring_fifo verification clean");
		else
			$display("stereo_frame_ring_fifo verification failed");
		$finish;
	end

endmodule
